// ===== hw/rtl/chm_pkg.sv =====
// shared types and constants of the chained hash map
package chm_pkg;

  // default sizes
  localparam int unsigned BUCKETS_DEF  = 1024;
  localparam int unsigned POOL_DEF     = 4096;
  localparam int unsigned KEY_BITS_DEF = 32;

  // fixed field widths of the stream payload
  localparam int unsigned OP_BITS   = 2;
  localparam int unsigned KEY_FIELD = 32;
  localparam int unsigned VAL_BITS  = 32;
  localparam int unsigned IN_BITS   = 64;
  localparam int unsigned OUT_BITS  = 40;

  // operation codes
  typedef enum logic [OP_BITS-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_HASH,
    ST_HCHK,
    ST_ECHK0,
    ST_ECHK,
    ST_APPEND,
    ST_RESP
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic init_step;
    logic load;
    logic mod_step;
    logic ent_rd_head;
    logic ent_rd_next;
    logic new_head;
    logic link_tail;
    logic new_entry;
    logic clr_pool;
    logic hit;
    logic resp;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  in_op;
    logic is_ins;
    logic pool_full;
    logic head_ok;
    logic bkt_ok;
    logic key_eq;
    logic next_valid;
    logic mod_done;
    logic init_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/chm_ram.sv =====
// generic single-write, single-read ram with registered read data
module chm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/chm_ctrl.sv =====
// controller state machine of the chained hash map
module chm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output chm_pkg::cmd_t cmd_o,
  input  chm_pkg::sts_t sts_i
);
  import chm_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sts_i.init_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.in_op)
            OP_LOOKUP: state_d = ST_HASH;
            OP_INSERT: state_d = sts_i.pool_full ? ST_RESP : ST_HASH;
            default:   state_d = ST_RESP;
          endcase
        end
      end
      ST_HASH: begin
        if (sts_i.mod_done) state_d = ST_HCHK;
      end
      ST_HCHK: begin
        state_d = sts_i.head_ok ? ST_ECHK0 : ST_RESP;
      end
      ST_ECHK0, ST_ECHK: begin
        if (state_q == ST_ECHK0 && !sts_i.bkt_ok) begin
          state_d = ST_RESP;
        end else if (sts_i.is_ins) begin
          state_d = sts_i.next_valid ? ST_ECHK : ST_APPEND;
        end else if (sts_i.key_eq || !sts_i.next_valid) begin
          state_d = ST_RESP;
        end else begin
          state_d = ST_ECHK;
        end
      end
      ST_APPEND: state_d = ST_RESP;
      ST_RESP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_INIT: cmd_o.init_step = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.clr_pool = (sts_i.in_op == OP_CLEAR);
        end
      end
      ST_HASH: cmd_o.mod_step = 1'b1;
      ST_HCHK: begin
        if (sts_i.head_ok) begin
          cmd_o.ent_rd_head = 1'b1;
        end else begin
          cmd_o.new_head = sts_i.is_ins;
        end
      end
      ST_ECHK0, ST_ECHK: begin
        if (state_q == ST_ECHK0 && !sts_i.bkt_ok) begin
          // stale head left by a clear: bucket is empty
          cmd_o.new_head = sts_i.is_ins;
        end else if (sts_i.is_ins) begin
          cmd_o.ent_rd_next = sts_i.next_valid;
          cmd_o.link_tail   = !sts_i.next_valid;
        end else if (sts_i.key_eq) begin
          cmd_o.hit = 1'b1;
        end else begin
          cmd_o.ent_rd_next = sts_i.next_valid;
        end
      end
      ST_APPEND: cmd_o.new_entry = 1'b1;
      ST_RESP:   cmd_o.resp = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/chm_dp.sv =====
// datapath of the chained hash map: bucket hash, head and entry rams, pool, result
module chm_dp #(
  parameter int unsigned BUCKETS      = chm_pkg::BUCKETS_DEF,
  parameter int unsigned POOL_ENTRIES = chm_pkg::POOL_DEF,
  parameter int unsigned KEY_BITS     = chm_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [chm_pkg::IN_BITS-1:0]   in_data_i,
  input  logic [chm_pkg::OP_BITS-1:0]   in_user_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [chm_pkg::OUT_BITS-1:0]  out_data_o,
  input  chm_pkg::cmd_t                 cmd_i,
  output chm_pkg::sts_t                 sts_o
);
  import chm_pkg::*;

  // widths
  localparam int unsigned KW   = (KEY_BITS < KEY_FIELD) ? KEY_BITS : KEY_FIELD;
  localparam int unsigned BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned IW   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned UW   = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned CW   = (UW > IW) ? UW : IW;
  localparam int unsigned KXW  = (KW > BW) ? KW : BW;
  localparam bit          POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  // entry word layout: key, value, bucket, next index, next valid
  localparam int unsigned V_LO = KW;
  localparam int unsigned B_LO = V_LO + VAL_BITS;
  localparam int unsigned N_LO = B_LO + BW;
  localparam int unsigned NV   = N_LO + IW;
  localparam int unsigned EW   = NV + 1;

  op_e                 op_q;
  logic [KW-1:0]       key_q;
  logic [VAL_BITS-1:0] val_q;
  logic [BW-1:0]       bucket;
  logic                mod_done;
  logic [BW-1:0]       icnt_q;
  logic [UW-1:0]       used_q;
  logic [IW-1:0]       cur_q, cur_d;
  logic                res_found_q, res_full_q;
  logic [VAL_BITS-1:0] res_val_q;
  logic                out_valid_q;
  logic                out_found_q, out_full_q;
  logic [VAL_BITS-1:0] out_val_q;
  logic [IW-1:0]       head_rd;
  logic                head_we;
  logic [BW-1:0]       head_waddr;
  logic [IW-1:0]       head_wdata;
  logic [EW-1:0]       ent_rd;
  logic                ent_we;
  logic [IW-1:0]       ent_waddr;
  logic [EW-1:0]       ent_wdata;
  logic [EW-1:0]       new_word;
  logic [EW-1:0]       link_word;
  logic [KW-1:0]       in_key;
  op_e                 in_op;
  logic                pool_full;
  logic                out_free;

  assign in_key    = in_data_i[KW-1:0];
  assign in_op     = op_e'(in_user_i);
  assign pool_full = (used_q == UW'(POOL_ENTRIES));
  assign out_free  = !out_valid_q || out_ready_i;

  // request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_op;
      key_q <= in_key;
      val_q <= in_data_i[KEY_FIELD +: VAL_BITS];
    end
  end

  // bucket index: key modulo bucket count
  if (BUCKETS == 1) begin : g_one
    assign bucket   = '0;
    assign mod_done = 1'b1;
  end else if (POW2) begin : g_pow2
    logic [KXW-1:0] key_x;
    assign key_x    = KXW'(key_q);
    assign bucket   = key_x[BW-1:0];
    assign mod_done = 1'b1;
  end else begin : g_recip
    // quotient by reciprocal multiplication, then remainder by subtraction, one step each
    localparam int unsigned SH = KW + BW;
    localparam int unsigned RW = KW + 2;
    localparam int unsigned PW = KW + RW;
    localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    logic [PW-1:0]  prod;
    logic [PW-1:0]  prod_sh;
    logic [KW-1:0]  quot_q;
    logic [KXW-1:0] quot_b;
    logic [KXW-1:0] rem;
    logic [BW-1:0]  rem_q;
    logic [1:0]     mcnt_q;
    assign prod    = PW'(key_q) * PW'(RECIP);
    assign prod_sh = prod >> SH;
    assign quot_b  = KXW'(quot_q) * KXW'(BUCKETS);
    assign rem     = KXW'(key_q) - quot_b;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mcnt_q <= '0;
      end else if (cmd_i.load) begin
        mcnt_q <= 2'd2;
      end else if (cmd_i.mod_step && mcnt_q != '0) begin
        mcnt_q <= mcnt_q - 2'd1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.mod_step && mcnt_q == 2'd2) begin
        quot_q <= prod_sh[KW-1:0];
      end
      if (cmd_i.mod_step && mcnt_q == 2'd1) begin
        rem_q <= rem[BW-1:0];
      end
    end
    assign bucket   = rem_q;
    assign mod_done = (mcnt_q == '0);
  end

  // init sweep counter and pool fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icnt_q <= '0;
      used_q <= '0;
    end else begin
      if (cmd_i.init_step) icnt_q <= icnt_q + BW'(1);
      if (cmd_i.clr_pool) begin
        used_q <= '0;
      end else if (cmd_i.new_head || cmd_i.new_entry) begin
        used_q <= used_q + UW'(1);
      end
    end
  end

  // head ram: cleared to index zero after reset, a head counts only if below the fill count
  assign head_we    = cmd_i.init_step || cmd_i.new_head;
  assign head_waddr = cmd_i.init_step ? icnt_q : bucket;
  assign head_wdata = cmd_i.init_step ? '0 : used_q[IW-1:0];

  chm_ram #(
    .WIDTH (IW),
    .DEPTH (BUCKETS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (bucket),
    .rdata_o (head_rd)
  );

  // entry ram words for a new entry and for linking the chain tail
  assign new_word  = {1'b0, IW'(0), bucket, val_q, key_q};
  assign link_word = {1'b1, used_q[IW-1:0], ent_rd[N_LO-1:0]};
  assign ent_we    = cmd_i.new_head || cmd_i.new_entry || cmd_i.link_tail;
  assign ent_waddr = cmd_i.link_tail ? cur_q : used_q[IW-1:0];
  assign ent_wdata = cmd_i.link_tail ? link_word : new_word;

  // chain walk pointer
  always_comb begin
    if (cmd_i.ent_rd_head) begin
      cur_d = head_rd;
    end else if (cmd_i.ent_rd_next) begin
      cur_d = ent_rd[N_LO +: IW];
    end else begin
      cur_d = cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  chm_ram #(
    .WIDTH (EW),
    .DEPTH (POOL_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (cur_d),
    .rdata_o (ent_rd)
  );

  // result of the current request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_found_q <= 1'b0;
      res_val_q   <= '0;
      res_full_q  <= (in_op == OP_INSERT) && pool_full;
    end else if (cmd_i.hit) begin
      res_found_q <= 1'b1;
      res_val_q   <= ent_rd[V_LO +: VAL_BITS];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      out_found_q <= res_found_q;
      out_val_q   <= res_val_q;
      out_full_q  <= res_full_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {(OUT_BITS - VAL_BITS - 2)'(0), out_full_q, out_val_q, out_found_q};

  // status
  always_comb begin
    sts_o            = '0;
    sts_o.in_op      = in_op;
    sts_o.is_ins     = (op_q == OP_INSERT);
    sts_o.pool_full  = pool_full;
    sts_o.head_ok    = (CW'(head_rd) < CW'(used_q));
    sts_o.bkt_ok     = (ent_rd[B_LO +: BW] == bucket);
    sts_o.key_eq     = (ent_rd[KW-1:0] == key_q);
    sts_o.next_valid = ent_rd[NV];
    sts_o.mod_done   = mod_done;
    sts_o.init_last  = (icnt_q == BW'(BUCKETS - 1));
    sts_o.out_free   = out_free;
  end

endmodule

// ===== hw/rtl/chained_hash_map.sv =====
// top level of the chained hash map: lookup, insert and clear over chained buckets
//
// channel    dir  handshake                    payload
// s_axis     in   s_axis_tvalid/s_axis_tready  tdata: key, value; tuser: opcode
// m_axis     out  m_axis_tvalid/m_axis_tready  tdata: found, result_value, pool_full
//
// after reset the head ram is swept through every bucket before the first request is taken
// lookup or insert: hash, head check, chain walk, response; appending to a chain adds a step
// clear, pool-full insert, unused opcodes skip hashing; a clear leaves head ram untouched
// BUCKETS not a power of two adds the reciprocal modulo steps to each lookup or insert
// a result waits in the output register; a new request is taken while it is not yet drained
module chained_hash_map #(
  parameter int unsigned BUCKETS      = chm_pkg::BUCKETS_DEF,
  parameter int unsigned POOL_ENTRIES = chm_pkg::POOL_DEF,
  parameter int unsigned KEY_BITS     = chm_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // key [31:0], value [63:32]
  input  logic [chm_pkg::IN_BITS-1:0]   s_axis_tdata,
  // opcode [1:0]
  input  logic [chm_pkg::OP_BITS-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // found [0], result_value [32:1], pool_full [33], zero fill [39:34]
  output logic [chm_pkg::OUT_BITS-1:0]  m_axis_tdata
);
  import chm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  chm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // datapath
  chm_dp #(
    .BUCKETS      (BUCKETS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .KEY_BITS     (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== tb/chm_checker.sv =====
// scoreboard of the chained hash map: predicts each response and checks it field by field
module chm_checker
  import chm_pkg::*;
#(
  parameter int unsigned BUCKETS      = BUCKETS_DEF,
  parameter int unsigned POOL_ENTRIES = POOL_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // key [31:0], value [63:32]
  input  logic [IN_BITS-1:0]  s_tdata_i,
  // opcode [1:0]
  input  logic [OP_BITS-1:0]  s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // found [0], result_value [32:1], pool_full [33], zero fill [39:34]
  input  logic [OUT_BITS-1:0] m_tdata_i,
  output int                  pending_o,
  output int                  errors_o
);

  typedef struct packed {
    logic                found;
    logic [VAL_BITS-1:0] value;
    logic                pool_full;
  } resp_t;

  // shadow copy of the table
  bit                    bkt_live    [BUCKETS];
  int unsigned           bkt_head    [BUCKETS];
  logic [KEY_FIELD-1:0]  slot_key    [POOL_ENTRIES];
  logic [VAL_BITS-1:0]   slot_val    [POOL_ENTRIES];
  int unsigned           slot_link   [POOL_ENTRIES];
  bit                    slot_linked [POOL_ENTRIES];
  int unsigned           slots_taken;

  // responses still owed by the block, oldest first
  resp_t owed_resp_q[$];

  // apply one request to the shadow table and return the response it must give
  function automatic resp_t apply_request(op_e op, logic [KEY_FIELD-1:0] key,
                                          logic [VAL_BITS-1:0] val);
    resp_t       res;
    int unsigned bkt;
    int unsigned walk;
    bit          done;
    res  = '0;
    bkt  = key % BUCKETS;
    done = 1'b0;
    case (op)
      OP_LOOKUP: begin
        if (bkt_live[bkt]) begin
          walk = bkt_head[bkt];
          // first matching key along the chain wins
          while (!done) begin
            if (slot_key[walk] == key) begin
              res.found = 1'b1;
              res.value = slot_val[walk];
              done      = 1'b1;
            end else if (!slot_linked[walk]) begin
              done = 1'b1;
            end else begin
              walk = slot_link[walk];
            end
          end
        end
      end
      OP_INSERT: begin
        if (slots_taken >= POOL_ENTRIES) begin
          res.pool_full = 1'b1;
        end else begin
          slot_key[slots_taken]    = key;
          slot_val[slots_taken]    = val;
          slot_linked[slots_taken] = 1'b0;
          if (!bkt_live[bkt]) begin
            bkt_head[bkt] = slots_taken;
            bkt_live[bkt] = 1'b1;
          end else begin
            // append at the tail of the chain
            walk = bkt_head[bkt];
            while (slot_linked[walk]) walk = slot_link[walk];
            slot_link[walk]   = slots_taken;
            slot_linked[walk] = 1'b1;
          end
          slots_taken++;
        end
      end
      OP_CLEAR: begin
        foreach (bkt_live[i]) bkt_live[i] = 1'b0;
        slots_taken = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    resp_t got;
    resp_t want;
    int    bad;
    if (!rst_ni) begin
      foreach (bkt_live[i]) bkt_live[i] = 1'b0;
      slots_taken = 0;
      owed_resp_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      bad = 0;
      // response side first: a response never belongs to a request taken on the same edge
      if (m_tvalid_i && m_tready_i) begin
        got.found     = m_tdata_i[0];
        got.value     = m_tdata_i[32:1];
        got.pool_full = m_tdata_i[33];
        if (owed_resp_q.size() == 0) begin
          $display("%0t unexpected response: found %0d value %h pool_full %0d",
                   $time, got.found, got.value, got.pool_full);
          bad++;
        end else begin
          want = owed_resp_q.pop_front();
          if (got.found !== want.found) begin
            $display("%0t found mismatch: expected %0d actual %0d",
                     $time, want.found, got.found);
            bad++;
          end
          if (got.value !== want.value) begin
            $display("%0t result_value mismatch: expected %h actual %h",
                     $time, want.value, got.value);
            bad++;
          end
          if (got.pool_full !== want.pool_full) begin
            $display("%0t pool_full mismatch: expected %0d actual %0d",
                     $time, want.pool_full, got.pool_full);
            bad++;
          end
        end
      end
      // request side
      if (s_tvalid_i && s_tready_i) begin
        owed_resp_q.push_back(apply_request(op_e'(s_tuser_i), s_tdata_i[31:0],
                                            s_tdata_i[63:32]));
      end
      pending_o <= owed_resp_q.size();
      errors_o  <= errors_o + bad;
    end
  end

endmodule

// ===== tb/tb_chained_hash_map.sv =====
// testbench top of the chained hash map: stimulus, flow control and verdict
module tb_chained_hash_map;
  import chm_pkg::*;

  localparam int unsigned LIMIT     = 1_000_000;
  localparam int unsigned FILL_REQS = 256;
  localparam int unsigned RAND_REQS = 1450;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // key [31:0], value [63:32]
  logic [IN_BITS-1:0]  s_axis_tdata;
  // opcode [1:0]
  logic [OP_BITS-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // found [0], result_value [32:1], pool_full [33], zero fill [39:34]
  logic [OUT_BITS-1:0] m_axis_tdata;

  int                  pending;
  int                  errors;
  logic                req_taken;
  int                  burst_left;
  int unsigned         cycle_cnt;
  // keys stored since the last clear, used to aim lookups at hits
  logic [31:0]         live_keys[$];
  int unsigned         stored;

  chained_hash_map uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  chm_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // request handshake seen at the rising edge
  always @(posedge clk_i) begin
    req_taken <= s_axis_tvalid && s_axis_tready;
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb_chained_hash_map: errors");
    $finish;
  end

  // response side stalls in spans of different character
  initial begin : sink
    int mode;
    int span;
    int tick;
    m_axis_tready = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((tick % 7) < 2);
        endcase
      end
    end
  end

  // drive one request and hold it until taken, then maybe pause between bursts
  task automatic issue(op_e op, logic [31:0] key, logic [31:0] val);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, key};
    do @(negedge clk_i); while (!req_taken);
    case (op)
      OP_INSERT: begin
        if (stored < POOL_DEF) begin
          live_keys.push_back(key);
          stored++;
        end
      end
      OP_CLEAR: begin
        live_keys.delete();
        stored = 0;
      end
      default: ;
    endcase
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(4, 12);
      else gap = $urandom_range(1, 3);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // hold off until every response has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // a quarter of the keys crowd into a few buckets to build long chains
  function automatic logic [31:0] rand_key();
    if ($urandom_range(0, 3) == 0) return ($urandom() & 32'hFFFF_FC00) | $urandom_range(0, 7);
    return $urandom();
  endfunction

  // stimulus
  initial begin : stim
    int unsigned r;
    logic [31:0] k;
    logic [31:0] v;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOOKUP;
    rst_ni        = 1'b0;
    burst_left    = 1;
    stored        = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table, zero value, extremes, collisions, duplicates, unused opcode
    issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    issue(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    issue(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    issue(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(OP_INSERT, 32'h0000_0400, 32'h1234_5678);
    issue(OP_LOOKUP, 32'h0000_0400, 32'h0000_0000);
    issue(OP_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
    issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    issue(OP_LOOKUP, 32'h0000_0800, 32'h0000_0000);
    issue(OP_INSERT, 32'h8000_03FF, 32'h8000_0001);
    issue(OP_LOOKUP, 32'h0000_03FF, 32'h0000_0000);
    issue(OP_LOOKUP, 32'h8000_03FF, 32'h0000_0000);
    issue(OP_NOP,    32'h0000_0055, 32'h0000_0001);
    issue(OP_LOOKUP, 32'h0000_0055, 32'h0000_0000);
    issue(OP_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0007);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    issue(OP_CLEAR,  32'h0000_0000, 32'h0000_0000);
    drain();

    // build long chains, then look back into them
    for (int i = 0; i < FILL_REQS; i++) issue(OP_INSERT, rand_key(), $urandom());
    for (int i = 0; i < 3; i++) issue(OP_INSERT, 32'hDEAD_0000 + i, $urandom());
    for (int i = 0; i < 16; i++) begin
      issue(OP_LOOKUP, live_keys[$urandom_range(0, live_keys.size() - 1)], $urandom());
    end
    issue(OP_LOOKUP, 32'hDEAD_0001, 32'h0000_0000);
    issue(OP_CLEAR, $urandom(), $urandom());
    drain();

    // random mix, lookups mostly aimed at stored keys
    for (int n = 0; n < RAND_REQS; n++) begin
      r = $urandom_range(0, 99);
      v = ($urandom_range(0, 19) == 0) ? 32'h0 : $urandom();
      if (r < 45) begin
        if (live_keys.size() > 0 && r < 32) k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else k = rand_key();
        issue(OP_LOOKUP, k, v);
      end else if (r < 88) begin
        if (live_keys.size() > 0 && r < 53) k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else k = rand_key();
        issue(OP_INSERT, k, v);
      end else if (r < 90) begin
        issue(OP_CLEAR, $urandom(), v);
      end else if (r < 93) begin
        issue(OP_NOP, $urandom(), v);
      end else begin
        issue(OP_LOOKUP, rand_key(), v);
      end
      if ($urandom_range(0, 149) == 0) drain();
    end

    drain();
    repeat (64) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("tb_chained_hash_map: clean");
    end else begin
      $display("tb_chained_hash_map: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/chm_pkg.sv
hw/rtl/chm_ram.sv
hw/rtl/chm_ctrl.sv
hw/rtl/chm_dp.sv
hw/rtl/chained_hash_map.sv
tb/chm_checker.sv
tb/tb_chained_hash_map.sv
